[hw/rtl/heat_ftcs_stencil_step_macros.svh]
// ----------------------------------------------------------------------------
// heat_ftcs_stencil_step_macros
// assertion shorthands for the stencil step block, clocked on clock and
// disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef HEAT_FTCS_STENCIL_STEP_MACROS_SVH
`define HEAT_FTCS_STENCIL_STEP_MACROS_SVH

// consequent checked in the same cycle
`define HFT_CHECK_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the next cycle
`define HFT_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/hftcs_pkg.sv]
// ----------------------------------------------------------------------------
// hftcs_pkg
// widths, register codes and pipeline types of the heat stencil step block
// ----------------------------------------------------------------------------
package hftcs_pkg;

   localparam int VALUE_W    = 32;
   localparam int COL_W      = 10;
   localparam int ROW_W      = 16;
   localparam int COEF_W     = 16;
   localparam int MAX_COLS   = 1024;
   localparam int ROW_ADDR_W = COL_W + 1;   // two row banks
   localparam int CSR_IDX_W  = 3;

   localparam int REQ_W      = 3 * VALUE_W;
   localparam int RSP_USED_W = VALUE_W + COL_W + ROW_W;
   localparam int RSP_W      = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_W - RSP_USED_W;

   localparam int PAIR_W     = VALUE_W + 1;            // sum of two values
   localparam int MULC_W     = COEF_W + 3;             // 1 - 2mux - 2muy
   localparam int PROD_C_W   = MULC_W + VALUE_W;
   localparam int PROD_M_W   = COEF_W + 1 + PAIR_W;
   localparam int PROD_T_W   = COEF_W + 1 + VALUE_W;
   localparam int SUM_W      = PROD_C_W + 2;
   localparam int FRAC_BITS  = 16;
   localparam int ROUND_W    = SUM_W - FRAC_BITS;
   localparam int ONE_Q16    = 65536;
   localparam int HALF_LSB   = 32768;
   localparam int SMP_W      = 2 * VALUE_W;

   localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MU_X      = 3'd0,
      CSR_MU_Y      = 3'd1,
      CSR_TIME_STEP = 3'd2,
      CSR_COLS_LAST = 3'd3,
      CSR_ROWS_LAST = 3'd4
   } csr_idx_type;

   // per-item control and pass-through data carried down the pipeline
   typedef struct packed {
      logic [COL_W-1:0]          col;
      logic [ROW_W-1:0]          row;
      logic [ROW_W-1:0]          prow;
      logic                      first;
      logic                      own;
      logic                      inner;
      logic                      done_first;
      logic                      done_own;
      logic signed [VALUE_W-1:0] bnd;
      logic signed [VALUE_W-1:0] g;
   } side_type;

endpackage

[hw/rtl/heat_ftcs_stencil_step.sv]
// ----------------------------------------------------------------------------
// heat_ftcs_stencil_step
// one explicit time step of the 2-d heat equation over a raster-order grid
// ----------------------------------------------------------------------------
// usage
//   req_* carries one grid point per request in raster order (column fastest):
//   old value, source sample and boundary value. rsp_* returns the updated
//   point of the row above, so results trail the inputs by one grid row.
//   interior points get the five-point stencil, edge points their boundary
//   value. on the last row each request also returns its own boundary point,
//   first the row above, then its own one; rsp_tlast marks the final result
//   of a request and rsp_tuser the final point of the grid.
//   csr_* writes mu_x, mu_y, time_step, cols_last and rows_last (index 0..4);
//   write them only while nothing is in flight.
//   a result is registered in stages 1, 2 and 3, then in the output register.
//   throughput: one request per cycle while results are taken; last-row
//   requests hold the single output register for two results.
//   reset clears the row and column counters and the pipeline; the row and
//   sample memories keep their contents, so no clearing pass is needed.
//   when rsp_tready is low the pipeline fills its four stages and then
//   drops req_tready; nothing is lost.
// ----------------------------------------------------------------------------
`include "heat_ftcs_stencil_step_macros.svh"

module heat_ftcs_stencil_step (
   input  logic                           clock,
   input  logic                           reset,
   // old_value, source_value, boundary_value
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [hftcs_pkg::REQ_W-1:0]    req_tdata,
   // new_value, column, row, zero pad
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [hftcs_pkg::RSP_W-1:0]    rsp_tdata,
   output logic                           rsp_tlast,   // last_of_run
   output logic                           rsp_tuser,   // grid_done
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [hftcs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hftcs_pkg::COEF_W-1:0]   csr_data
);
   import hftcs_pkg::*;

   // configuration
   logic [COEF_W-1:0] mu_x_ff, mu_y_ff, time_step_ff;
   logic [COL_W-1:0]  cols_last_ff;
   logic [ROW_W-1:0]  rows_last_ff;

   // raster position of the next request
   logic [COL_W-1:0]  col_cnt_ff, col_cnt_in;
   logic [ROW_W-1:0]  row_cnt_ff, row_cnt_in;

   // memories: two row banks of old values, one row of {boundary, source}
   logic signed [VALUE_W-1:0] row_mem [2**ROW_ADDR_W];
   logic [SMP_W-1:0]          smp_mem [MAX_COLS];
   logic signed [VALUE_W-1:0] rd_a_ff, rd_b_ff;   // row j-1 at i+1, row j-2 at i
   logic [SMP_W-1:0]          rd_s_ff;

   // sliding window over row j-1
   logic signed [VALUE_W-1:0] left_ff, center_ff, row0_ff;

   // pipeline
   logic p1_valid_ff, p2_valid_ff, p3_valid_ff, out_valid_ff;
   side_type p1_side_ff, p2_side_ff, p3_side_ff, o_side_ff, side_in;
   logic signed [VALUE_W-1:0]  p1_ctr_ff, p1_src_ff;
   logic signed [PAIR_W-1:0]   p1_lr_ff, p1_du_ff, lr_in, du_in;
   logic signed [PROD_C_W-1:0] p2_prod_c_ff, prod_c_in;
   logic signed [PROD_M_W-1:0] p2_prod_x_ff, p2_prod_y_ff, prod_x_in, prod_y_in;
   logic signed [PROD_T_W-1:0] p2_prod_t_ff, prod_t_in;
   logic signed [SUM_W-1:0]    p3_sa_ff, p3_sb_ff, sa_in, sb_in, total;
   logic signed [MULC_W-1:0]   coef;
   logic signed [ROUND_W-1:0]  rounded;
   logic [VALUE_W-1:0]         sat_value, o_value_in;
   logic [VALUE_W-1:0]         o_value_ff;
   logic                       o_first_ff, o_own_ff;

   // request fields
   logic signed [VALUE_W-1:0] old_value, source_value, boundary_value;
   logic req_accept, rsp_hs, rsp_last_hs, out_free, en1, en2, en3;
   logic [ROW_ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
   logic [ROW_W-1:0]      prow;
   logic [VALUE_W-1:0]    out_val;
   logic [ROW_W-1:0]      out_row;

   assign old_value      = $signed(req_tdata[VALUE_W-1:0]);
   assign source_value   = $signed(req_tdata[2*VALUE_W-1:VALUE_W]);
   assign boundary_value = $signed(req_tdata[3*VALUE_W-1:2*VALUE_W]);

   // ---------------------------------------------------------------- flow
   // a stage moves on when it is empty or the stage after it moves on
   assign rsp_hs      = rsp_tvalid && rsp_tready;
   assign rsp_last_hs = rsp_hs && !(o_first_ff && o_own_ff);
   assign out_free    = !out_valid_ff || rsp_last_hs;
   assign en3         = !p3_valid_ff || out_free;
   assign en2         = !p2_valid_ff || en3;
   assign en1         = !p1_valid_ff || en2;
   assign req_tready  = en1 && !reset;
   assign req_accept  = req_tvalid && req_tready;

   // --------------------------------------------------------- config port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mu_x_ff      <= COEF_W'(16384);
         mu_y_ff      <= COEF_W'(16384);
         time_step_ff <= COEF_W'(655);
         cols_last_ff <= COL_W'(63);
         rows_last_ff <= ROW_W'(63);
      end else if (csr_valid && csr_ready) begin
         case (csr_idx_type'(csr_index))
            CSR_MU_X:      mu_x_ff      <= csr_data;
            CSR_MU_Y:      mu_y_ff      <= csr_data;
            CSR_TIME_STEP: time_step_ff <= csr_data;
            CSR_COLS_LAST: cols_last_ff <= csr_data[COL_W-1:0];
            CSR_ROWS_LAST: rows_last_ff <= csr_data[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------ counters
   // past the last column (also after cols_last was lowered) wrap the row;
   // a row at or beyond rows_last wraps the grid
   always_comb begin
      col_cnt_in = col_cnt_ff + COL_W'(1);
      row_cnt_in = row_cnt_ff;
      if (col_cnt_ff >= cols_last_ff) begin
         col_cnt_in = '0;
         row_cnt_in = (row_cnt_ff >= rows_last_ff) ? '0 : row_cnt_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else if (req_accept) begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
      end
   end

   // ------------------------------------------------------------ memories
   // the current point goes to the bank of row j; reads for the next point
   // are issued in the same cycle, so the data waits in rd_*_ff until that
   // point arrives. a read that hits the entry being written takes the new
   // data (only possible on very narrow grids)
   assign wr_addr   = {row_cnt_ff[0], col_cnt_ff};
   assign rd_addr_a = {~row_cnt_in[0], COL_W'(col_cnt_in + COL_W'(1))};
   assign rd_addr_b = {row_cnt_in[0], col_cnt_in};

   always_ff @(posedge clock) begin
      if (req_accept) begin
         row_mem[wr_addr]    <= old_value;
         smp_mem[col_cnt_ff] <= {boundary_value, source_value};
         if (rd_addr_a == wr_addr) begin
            rd_a_ff <= old_value;
         end else begin
            rd_a_ff <= row_mem[rd_addr_a];
         end
         if (rd_addr_b == wr_addr) begin
            rd_b_ff <= old_value;
         end else begin
            rd_b_ff <= row_mem[rd_addr_b];
         end
         if (col_cnt_in == col_cnt_ff) begin
            rd_s_ff <= {boundary_value, source_value};
         end else begin
            rd_s_ff <= smp_mem[col_cnt_in];
         end
      end
   end

   // window: center is row j-1 at i, left at i-1, right comes from rd_a_ff.
   // column 0 of row j-1 is kept aside since no read fetches it
   always_ff @(posedge clock) begin
      if (req_accept) begin
         center_ff <= rd_a_ff;
         if (col_cnt_ff == '0) begin
            left_ff <= row0_ff;
            row0_ff <= old_value;
         end else begin
            left_ff <= center_ff;
         end
      end
   end

   // ------------------------------------------------------- stage 1 input
   assign prow  = row_cnt_ff - ROW_W'(1);
   assign lr_in = PAIR_W'(left_ff) + PAIR_W'(rd_a_ff);
   assign du_in = PAIR_W'(rd_b_ff) + PAIR_W'(old_value);

   always_comb begin
      side_in.col        = col_cnt_ff;
      side_in.row        = row_cnt_ff;
      side_in.prow       = prow;
      side_in.first      = (row_cnt_ff != '0);
      side_in.own        = (row_cnt_ff >= rows_last_ff);
      // interior: row above is neither first nor last, column not on an edge
      side_in.inner      = (row_cnt_ff >= ROW_W'(2)) && (prow < rows_last_ff) &&
                           (col_cnt_ff != '0) && (col_cnt_ff < cols_last_ff);
      side_in.done_first = (col_cnt_ff == cols_last_ff) && (prow == rows_last_ff);
      side_in.done_own   = (col_cnt_ff == cols_last_ff) && (row_cnt_ff == rows_last_ff);
      side_in.bnd        = $signed(rd_s_ff[SMP_W-1:VALUE_W]);
      side_in.g          = boundary_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (en1) begin
         p1_valid_ff <= req_accept;
      end
      if (req_accept) begin
         p1_side_ff <= side_in;
         p1_ctr_ff  <= center_ff;
         p1_lr_ff   <= lr_in;
         p1_du_ff   <= du_in;
         p1_src_ff  <= $signed(rd_s_ff[VALUE_W-1:0]);
      end
   end

   // ------------------------------------------------------ stage 2 products
   assign coef      = MULC_W'(ONE_Q16) - $signed({2'b00, mu_x_ff, 1'b0})
                                       - $signed({2'b00, mu_y_ff, 1'b0});
   assign prod_c_in = coef * p1_ctr_ff;
   assign prod_x_in = $signed({1'b0, mu_x_ff}) * p1_lr_ff;
   assign prod_y_in = $signed({1'b0, mu_y_ff}) * p1_du_ff;
   assign prod_t_in = $signed({1'b0, time_step_ff}) * p1_src_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (en2) begin
         p2_valid_ff <= p1_valid_ff;
      end
      if (en2 && p1_valid_ff) begin
         p2_side_ff   <= p1_side_ff;
         p2_prod_c_ff <= prod_c_in;
         p2_prod_x_ff <= prod_x_in;
         p2_prod_y_ff <= prod_y_in;
         p2_prod_t_ff <= prod_t_in;
      end
   end

   // ---------------------------------------------------- stage 3 pair sums
   // rounding half is folded into the second pair
   assign sa_in = SUM_W'(p2_prod_c_ff) + SUM_W'(p2_prod_x_ff);
   assign sb_in = SUM_W'(p2_prod_y_ff) + SUM_W'(p2_prod_t_ff) + SUM_W'(HALF_LSB);

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (en3) begin
         p3_valid_ff <= p2_valid_ff;
      end
      if (en3 && p2_valid_ff) begin
         p3_side_ff <= p2_side_ff;
         p3_sa_ff   <= sa_in;
         p3_sb_ff   <= sb_in;
      end
   end

   // --------------------------------------------- round, saturate, output
   assign total   = p3_sa_ff + p3_sb_ff;
   assign rounded = ROUND_W'(total >>> FRAC_BITS);

   always_comb begin
      if (rounded[ROUND_W-1:VALUE_W-1] == '0 || rounded[ROUND_W-1:VALUE_W-1] == '1) begin
         sat_value = rounded[VALUE_W-1:0];
      end else begin
         sat_value = rounded[ROUND_W-1] ? VAL_MIN : VAL_MAX;
      end
      o_value_in = p3_side_ff.inner ? sat_value : p3_side_ff.bnd;
   end

   // one entry holds up to two results: row above first, then own point
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= p3_valid_ff && (p3_side_ff.first || p3_side_ff.own);
      end
      if (out_free) begin
         if (p3_valid_ff) begin
            o_side_ff  <= p3_side_ff;
            o_value_ff <= o_value_in;
            o_first_ff <= p3_side_ff.first;
            o_own_ff   <= p3_side_ff.own;
         end
      end else if (rsp_hs) begin
         o_first_ff <= 1'b0;
      end
   end

   assign out_val    = o_first_ff ? o_value_ff : o_side_ff.g;
   assign out_row    = o_first_ff ? o_side_ff.prow : o_side_ff.row;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, out_row, o_side_ff.col, out_val};
   assign rsp_tlast  = !(o_first_ff && o_own_ff);
   assign rsp_tuser  = o_first_ff ? o_side_ff.done_first : o_side_ff.done_own;

   // ---------------------------------------------------------- assertions
   `HFT_CHECK_NEXT(a_prefetch_hold, !req_accept, $stable(rd_a_ff) && $stable(rd_b_ff), "prefetched row data moved without a request")
   `HFT_CHECK_NOW(a_entry_nonempty, out_valid_ff, o_first_ff || o_own_ff, "output entry holds no result")
   `HFT_CHECK_NEXT(a_own_follows, rsp_hs && o_first_ff && o_own_ff, out_valid_ff && !o_first_ff && o_own_ff, "own boundary result lost after row-above result")
   `HFT_CHECK_NEXT(a_stage3_hold, p3_valid_ff && !en3, p3_valid_ff && out_valid_ff, "stage 3 dropped while output busy")

endmodule

[test/heat_ftcs_stencil_step_tb.sv]
// ----------------------------------------------------------------------------
// heat_ftcs_stencil_step_tb
// self-checking bench for the streamed ftcs heat stencil step: a short sweep
// of hand-built grids with pinned results, then random grids of many shapes
// (tiny, wide, tall, cut and shrunk mid grid) under random request gaps and
// result stalls, every result checked against a bit-exact stencil predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module heat_ftcs_stencil_step_tb;

   import hftcs_pkg::*;

   localparam int ITEM_TARGET    = 1850;
   localparam int SETTLE_CYCLES  = 8;      // drain time for the four pipeline stages
   localparam int END_DRAIN      = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;
   localparam int WIDE_GRID_NO   = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_BASE = 3'd5;   // 5..7 are unmapped

   localparam longint SAT_HI = (longint'(1) <<< (VALUE_W - 1)) - 1;
   localparam longint SAT_LO = -SAT_HI - 1;

   // one result point as it leaves the block
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [COL_W-1:0]   column;
      logic [ROW_W-1:0]   row;
      logic               last_of_run;
      logic               grid_done;
   } grid_point_t;

   // directed sweep: grid settings and their points in raster order
   typedef struct packed {
      logic [COEF_W-1:0] mu_x;
      logic [COEF_W-1:0] mu_y;
      logic [COEF_W-1:0] dt;
      logic [COL_W-1:0]  cols;
      logic [ROW_W-1:0]  rows;
      logic [7:0]        points;
   } sweep_grid_t;

   typedef struct packed {
      logic [VALUE_W-1:0] old_v;
      logic [VALUE_W-1:0] src_v;
      logic [VALUE_W-1:0] bnd_v;
      logic               pinned;        // first result value typed in below
      logic [VALUE_W-1:0] first_value;
   } sweep_point_t;

   localparam sweep_grid_t SWEEP_GRIDS [4] = '{
      // 3x3, largest coefficients: the one interior point saturates high
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd2, 16'd2, 8'd9},
      // 3x3, zero mu and full dt: interior saturates low
      '{16'h0000, 16'h0000, 16'hFFFF, 10'd2, 16'd2, 8'd9},
      // single point grid: every request is first and last row at once
      '{16'h4000, 16'h4000, 16'd655, 10'd0, 16'd0, 8'd2},
      // 2x2 grid: no interior at all
      '{16'h4000, 16'h4000, 16'd655, 10'd1, 16'd1, 8'd4}
   };

   localparam sweep_point_t SWEEP_POINTS [24] = '{
      // grid 0, row 0: no results yet
      '{VAL_MAX, 32'h0, 32'h0001_0000, 1'b0, 32'h0},
      '{VAL_MAX, 32'h0, 32'h0002_0000, 1'b0, 32'h0},
      '{VAL_MAX, 32'h0, 32'h0003_0000, 1'b0, 32'h0},
      // row 1 returns row 0 boundaries
      '{VAL_MAX, 32'h0, 32'h0004_0000, 1'b1, 32'h0001_0000},
      '{VAL_MIN, VAL_MAX, 32'h0005_0000, 1'b1, 32'h0002_0000},
      '{VAL_MAX, 32'h0, 32'h0006_0000, 1'b1, 32'h0003_0000},
      // last row: row 1 results plus own boundaries
      '{VAL_MAX, 32'h0, VAL_MIN, 1'b1, 32'h0004_0000},
      '{VAL_MAX, 32'h0, VAL_MAX, 1'b1, VAL_MAX},
      '{32'h0, 32'h0, 32'hFFFF_0000, 1'b1, 32'h0006_0000},
      // grid 1
      '{32'h0, 32'h0, 32'h0000_0001, 1'b0, 32'h0},
      '{32'h0, 32'h0, 32'h0000_0002, 1'b0, 32'h0},
      '{32'h0, 32'h0, 32'h0000_0003, 1'b0, 32'h0},
      '{VAL_MAX, VAL_MIN, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
      '{VAL_MIN, VAL_MIN, 32'h8000_0001, 1'b1, 32'h0000_0002},
      '{VAL_MAX, VAL_MAX, 32'h7FFF_FFFE, 1'b1, 32'h0000_0003},
      '{32'h0, 32'h0, 32'h1234_5678, 1'b1, 32'hFFFF_FFFF},
      '{VAL_MAX, 32'h0, 32'hEDCB_A988, 1'b1, VAL_MIN},
      '{32'h0, 32'h0, 32'h0, 1'b1, 32'h7FFF_FFFE},
      // grid 2: result is the request's own boundary
      '{32'h0, 32'h0, VAL_MAX, 1'b1, VAL_MAX},
      '{32'h0, 32'h0, VAL_MIN, 1'b1, VAL_MIN},
      // grid 3
      '{32'h0, 32'h0, 32'h0000_8000, 1'b0, 32'h0},
      '{32'h0, 32'h0, 32'hFFFF_8000, 1'b0, 32'h0},
      '{32'h0, 32'h0, 32'h0, 1'b1, 32'h0000_8000},
      '{32'h0, 32'h0, 32'h0001_0000, 1'b1, 32'hFFFF_8000}
   };

   // ------------------------------------------------------------------------
   // dut signals, all driven to known values from time zero
   // ------------------------------------------------------------------------
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_W-1:0]       rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [COEF_W-1:0]      csr_data   = '0;

   heat_ftcs_stencil_step u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // stencil predictor: register copies, row history and raster position
   // ------------------------------------------------------------------------
   logic [COEF_W-1:0]         coef_mu_x = 16'd16384;
   logic [COEF_W-1:0]         coef_mu_y = 16'd16384;
   logic [COEF_W-1:0]         coef_dt   = 16'd655;
   logic [COL_W-1:0]          last_col  = 10'd63;
   logic [ROW_W-1:0]          last_row  = 16'd63;
   logic [COL_W-1:0]          col_pos   = '0;
   logic [ROW_W-1:0]          row_pos   = '0;

   // two banks of old values, indexed by row parity; the newest row sits in
   // the bank of its parity, the one before in the other bank
   logic signed [VALUE_W-1:0] old_rows        [2*MAX_COLS];
   logic signed [VALUE_W-1:0] lagged_source   [MAX_COLS];
   logic signed [VALUE_W-1:0] lagged_boundary [MAX_COLS];

   grid_point_t               expected_points [$];

   bit                        req_idle_on  = 1'b0;
   bit                        rsp_stall_on = 1'b0;
   int                        items_sent   = 0;
   int                        mismatch_count = 0;

   // Q.32 sum back to Q.16: add half an lsb, floor, clamp
   function automatic logic [VALUE_W-1:0] round_saturate(input longint acc);
      longint q;
      q = (acc + HALF_LSB) >>> FRAC_BITS;
      if (q > SAT_HI) return VAL_MAX;
      if (q < SAT_LO) return VAL_MIN;
      return VALUE_W'(q);
   endfunction

   // queue the results one request causes, then advance the history
   task automatic ftcs_update(input logic [VALUE_W-1:0] u_bits, f_bits, g_bits,
                              input logic pinned, input logic [VALUE_W-1:0] pin_value);
      int          i, j, ec, er, pb, qb;
      bit          own;
      longint      centre_w, acc;
      grid_point_t pt;
      i   = col_pos;
      j   = row_pos;
      ec  = last_col;
      er  = last_row;
      own = (j >= er);
      pb  = ((j + 1) % 2) * MAX_COLS;   // bank of row j-1
      qb  = (j % 2) * MAX_COLS;         // bank of row j-2, about to be overwritten
      if (j >= 1) begin
         pt.column      = COL_W'(i);
         pt.row         = ROW_W'(j - 1);
         pt.last_of_run = !own;
         pt.grid_done   = (i == ec) && (j - 1 == er);
         if (j - 1 >= 1 && j - 1 < er && i >= 1 && i < ec) begin
            centre_w = longint'(ONE_Q16) - 2 * longint'(coef_mu_x)
                     - 2 * longint'(coef_mu_y);
            acc = centre_w * longint'(old_rows[pb + i])
                + longint'(coef_mu_x) * (longint'(old_rows[pb + i - 1])
                                       + longint'(old_rows[pb + i + 1]))
                + longint'(coef_mu_y) * (longint'(old_rows[qb + i])
                                       + longint'($signed(u_bits)))
                + longint'(coef_dt) * longint'(lagged_source[i]);
            pt.value = round_saturate(acc);
         end else begin
            pt.value = lagged_boundary[i];
         end
         if (pinned) pt.value = pin_value;
         expected_points.push_back(pt);
      end
      if (own) begin
         pt.value       = g_bits;
         pt.column      = COL_W'(i);
         pt.row         = ROW_W'(j);
         pt.last_of_run = 1'b1;
         pt.grid_done   = (i == ec) && (j == er);
         expected_points.push_back(pt);
      end

      old_rows[qb + i]   = u_bits;
      lagged_source[i]   = f_bits;
      lagged_boundary[i] = g_bits;

      // a position past a lowered bound wraps at the next test
      if (i >= ec) begin
         col_pos = '0;
         row_pos = (j >= er) ? '0 : ROW_W'(j + 1);
      end else begin
         col_pos = COL_W'(i + 1);
      end
   endtask

   // ------------------------------------------------------------------------
   // random helpers
   // ------------------------------------------------------------------------
   // mostly back to back, sometimes a short gap, rarely a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Q15.16 sample: extremes, zero, -1 lsb, full range or a few hundred units
   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return VAL_MAX;
         1:       return VAL_MIN;
         2:       return '0;
         3:       return '1;
         4, 5:    return $urandom;
         default: return VALUE_W'($urandom_range(0, 1 << 25) - (1 << 24));
      endcase
   endfunction

   // mostly stable coefficients, sometimes anything the field holds
   function automatic logic [COEF_W-1:0] pick_coef();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return COEF_W'($urandom_range(0, 65535));
         default: return COEF_W'($urandom_range(0, 16384));
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // drivers: everything changes with nonblocking assignments at the edge
   // ------------------------------------------------------------------------
   // one request; tvalid stays high into the next call when no gap is drawn
   task automatic send_point(input logic [VALUE_W-1:0] old_v, src_v, bnd_v,
                             input logic pinned, input logic [VALUE_W-1:0] pin_value);
      int gap;
      gap = req_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {bnd_v, src_v, old_v};
      do @(posedge clock); while (!req_tready);
      ftcs_update(old_v, src_v, bnd_v, pinned, pin_value);
      items_sent++;
   endtask

   // leaves csr_valid high; the caller drops it after its last write
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [COEF_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MU_X:      coef_mu_x = value;
         CSR_MU_Y:      coef_mu_y = value;
         CSR_TIME_STEP: coef_dt   = value;
         CSR_COLS_LAST: last_col  = value[COL_W-1:0];
         CSR_ROWS_LAST: last_row  = value;
         default:       ;
      endcase
   endtask

   // stop requests, let every expected point out, then give first-row
   // requests (which return nothing) time to leave the pipeline
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // full register set at a grid boundary; cols_last goes out with junk above
   // its ten bits, and now and then an unmapped index is written first
   task automatic program_grid(input logic [COEF_W-1:0] mx, my, dt,
                               input logic [COL_W-1:0] cl, input logic [ROW_W-1:0] rl);
      logic [COEF_W-COL_W-1:0] junk;
      junk = $urandom;
      settle_block();
      if ($urandom_range(0, 3) == 0)
         write_csr(CSR_IDX_W'(CSR_SPARE_BASE + $urandom_range(0, 2)), $urandom);
      write_csr(CSR_MU_X, mx);
      write_csr(CSR_MU_Y, my);
      write_csr(CSR_TIME_STEP, dt);
      write_csr(CSR_COLS_LAST, {junk, cl});
      write_csr(CSR_ROWS_LAST, rl);
      csr_valid <= 1'b0;
   endtask

   // result side back-pressure: runs of ready broken by random stalls
   int ready_hold = 0;
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold = ready_hold - 1;
      end else if (rsp_stall_on && $urandom_range(0, 2) == 0) begin
         rsp_tready <= 1'b0;
         ready_hold = pick_gap();
      end else begin
         rsp_tready <= 1'b1;
         ready_hold = $urandom_range(0, 5);
      end
   end

   // ------------------------------------------------------------------------
   // result checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      grid_point_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.value       = rsp_tdata[VALUE_W-1:0];
         got.column      = rsp_tdata[VALUE_W +: COL_W];
         got.row         = rsp_tdata[VALUE_W+COL_W +: ROW_W];
         got.last_of_run = rsp_tlast;
         got.grid_done   = rsp_tuser;
         if (expected_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: unexpected result value %h col %0d row %0d last %b done %b",
                        $realtime, got.value, got.column, got.row,
                        got.last_of_run, got.grid_done);
         end else begin
            want = expected_points.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"%0t: mismatch expected value %h col %0d row %0d last %b done %b,",
                            " got value %h col %0d row %0d last %b done %b"},
                           $realtime, want.value, want.column, want.row,
                           want.last_of_run, want.grid_done, got.value, got.column,
                           got.row, got.last_of_run, got.grid_done);
            end
         end
      end
   end

   // watchdog: any handshake on any channel counts as progress
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("heat_ftcs_stencil_step_tb failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      int                pt;
      int                grid_no;
      int                cut_at;
      int                row_cap;
      bit                tall;
      logic [COL_W-1:0]  cl;
      logic [ROW_W-1:0]  rl;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed sweep, idling drawn per grid
      pt = 0;
      foreach (SWEEP_GRIDS[g]) begin
         req_idle_on  = $urandom_range(0, 1);
         rsp_stall_on = $urandom_range(0, 1);
         program_grid(SWEEP_GRIDS[g].mu_x, SWEEP_GRIDS[g].mu_y, SWEEP_GRIDS[g].dt,
                      SWEEP_GRIDS[g].cols, SWEEP_GRIDS[g].rows);
         for (int k = 0; k < int'(SWEEP_GRIDS[g].points); k++) begin
            send_point(SWEEP_POINTS[pt].old_v, SWEEP_POINTS[pt].src_v,
                       SWEEP_POINTS[pt].bnd_v, SWEEP_POINTS[pt].pinned,
                       SWEEP_POINTS[pt].first_value);
            pt++;
         end
      end

      // random grids, each run to its wrap back to the origin so the next
      // setting never exposes a row-buffer entry this grid did not write
      grid_no = 0;
      while (items_sent < ITEM_TARGET) begin
         req_idle_on  = ($urandom_range(0, 3) != 0);
         rsp_stall_on = ($urandom_range(0, 3) != 0);
         tall   = 1'b0;
         cut_at = 0;
         if (grid_no == WIDE_GRID_NO) begin
            // widest row, one row only: every request returns its own point
            cl = COL_W'(MAX_COLS - 1);
            rl = '0;
         end else begin
            case ($urandom_range(0, 9))
               0: begin
                  cl = COL_W'($urandom_range(0, 1));
                  rl = ROW_W'($urandom_range(0, 3));
               end
               1: begin
                  cl = COL_W'($urandom_range(0, 3));
                  rl = ROW_W'($urandom_range(0, 1));
               end
               2: begin
                  // huge row count, cut short and shrunk to at most two rows past the current row
                  cl   = COL_W'($urandom_range(2, 8));
                  rl   = ($urandom_range(0, 1) == 1) ? '1 : ROW_W'($urandom_range(0, 65535));
                  tall = 1'b1;
               end
               3: begin
                  cl = COL_W'($urandom_range(40, 120));
                  rl = ROW_W'($urandom_range(2, 4));
               end
               default: begin
                  cl = COL_W'($urandom_range(2, 20));
                  rl = ROW_W'($urandom_range(2, 8));
               end
            endcase
            if (tall)
               cut_at = (int'(cl) + 1) * $urandom_range(1, 4) + $urandom_range(0, cl);
            else if ($urandom_range(0, 5) == 0)
               cut_at = $urandom_range(1, (int'(cl) + 1) * (int'(rl) + 1) - 1);
         end
         program_grid(pick_coef(), pick_coef(), pick_coef(), cl, rl);

         if (cut_at > 0) begin
            repeat (cut_at)
               send_point(pick_value(), pick_value(), pick_value(), 1'b0, '0);
            // bounds only shrink mid grid; the position may end up past them
            settle_block();
            row_cap = (int'(row_pos) + 2 < int'(last_row)) ? int'(row_pos) + 2
                                                            : int'(last_row);
            if ($urandom_range(0, 1) == 1) write_csr(CSR_MU_Y, pick_coef());
            write_csr(CSR_COLS_LAST, COEF_W'($urandom_range(0, last_col)));
            write_csr(CSR_ROWS_LAST, COEF_W'($urandom_range(0, row_cap)));
            csr_valid <= 1'b0;
         end

         do send_point(pick_value(), pick_value(), pick_value(), 1'b0, '0);
         while (col_pos != '0 || row_pos != '0);
         grid_no++;
      end

      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (END_DRAIN) @(posedge clock);
      if (mismatch_count == 0)
         $display("heat_ftcs_stencil_step_tb passed");
      else
         $display("heat_ftcs_stencil_step_tb failed");
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/hftcs_pkg.sv
hw/rtl/heat_ftcs_stencil_step.sv
test/heat_ftcs_stencil_step_tb.sv
